>>> hw/rtl/tch_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tch_pkg;

    // Request codes carried by req_type
    typedef enum logic [1:0] {
        REQ_CONNECT = 2'd0,
        REQ_SEGMENT = 2'd1,
        REQ_TICK    = 2'd2
    } req_code_t;

    // Status codes reported with every result word
    typedef enum logic [1:0] {
        STAT_NONE      = 2'd0,
        STAT_CONNECTED = 2'd1,
        STAT_TIMEOUT   = 2'd2,
        STAT_REJECTED  = 2'd3
    } status_t;

    localparam logic [7:0]  FLAG_SYN      = 8'h02;
    localparam logic [7:0]  FLAG_ACK      = 8'h10;
    localparam logic [31:0] ISN_MULT      = 32'd2654435761;
    localparam logic [15:0] PORT_START    = 16'd40000;
    localparam logic [15:0] PORT_LOW      = 16'd32768;
    localparam logic [15:0] PORT_HIGH     = 16'd60999;
    localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
    localparam logic [15:0] MIN_HDR       = 16'd20;
    localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] peer_ip;
        logic [15:0] remote_port;
        logic [31:0] now_ms;
        logic [31:0] rx_src_ip;
        logic [15:0] rx_src_port;
        logic [15:0] rx_dst_port;
        logic [7:0]  rx_flags;
        logic [31:0] rx_seq;
        logic [31:0] rx_ack;
        logic [3:0]  rx_data_offset;
        logic [15:0] rx_seg_len;
    } item_t;

    typedef struct packed {
        logic        send_valid;
        logic [31:0] send_dst_ip;
        logic [15:0] send_src_port;
        logic [15:0] send_dst_port;
        logic [31:0] send_seq;
        logic [31:0] send_ack;
        logic [7:0]  send_flags;
        status_t     status;
    } result_t;

    // Pipeline control between the stages
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/tch_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module tch_in_reg (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire tch_pkg::item_t  in_item,
    input  wire logic            advance,
    output logic                 stage_valid,
    output tch_pkg::item_t       stage_item
);

    logic           valid_reg;
    logic           valid_next;
    tch_pkg::item_t item_reg;

    // accept when empty or when the held word moves on this cycle
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_valid ? 1'b1 : (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

`default_nettype wire

>>> hw/rtl/tch_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module tch_engine (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [15:0]         cfg_wr_data,
    input  wire tch_pkg::stage_ctl_t ctl,
    input  wire tch_pkg::item_t      item,
    output tch_pkg::result_t         result
);

    logic        process;
    logic [15:0] timeout_reg;
    logic        attempt_active_reg, attempt_active_next;
    logic [31:0] pending_peer_ip_reg, pending_peer_ip_next;
    logic [15:0] pending_remote_port_reg, pending_remote_port_next;
    logic [15:0] pending_local_port_reg, pending_local_port_next;
    logic [31:0] initial_seq_reg, initial_seq_next;
    logic [15:0] elapsed_ms_reg, elapsed_ms_next;
    logic [15:0] port_counter_reg, port_counter_next;

    logic [15:0] port_inc;
    logic [15:0] port_pick;
    logic [31:0] isn_prod;
    logic [31:0] isn;
    logic [31:0] isn_plus1;
    logic [15:0] hdr_len;
    logic        hdr_ok;
    logic        seg_match;
    logic [15:0] elapsed_inc;

    assign process = ctl.valid && ctl.advance;

    assign port_inc  = port_counter_reg + 16'd1;
    assign port_pick = (port_inc < tch_pkg::PORT_LOW || port_inc > tch_pkg::PORT_HIGH)
                       ? tch_pkg::PORT_LOW : port_inc;
    assign isn_prod  = item.now_ms * tch_pkg::ISN_MULT;
    assign isn       = isn_prod | 32'd1;
    assign isn_plus1 = initial_seq_reg + 32'd1;

    assign hdr_len = {10'd0, item.rx_data_offset, 2'b00};
    assign hdr_ok  = (item.rx_seg_len >= tch_pkg::MIN_HDR) && (hdr_len >= tch_pkg::MIN_HDR)
                     && (hdr_len <= item.rx_seg_len);

    assign seg_match = attempt_active_reg
                       && (pending_local_port_reg == item.rx_dst_port)
                       && (pending_remote_port_reg == item.rx_src_port)
                       && (pending_peer_ip_reg == item.rx_src_ip)
                       && ((item.rx_flags & (tch_pkg::FLAG_SYN | tch_pkg::FLAG_ACK))
                           == (tch_pkg::FLAG_SYN | tch_pkg::FLAG_ACK))
                       && (item.rx_ack == isn_plus1);

    assign elapsed_inc = (elapsed_ms_reg == tch_pkg::ELAPSED_MAX)
                         ? elapsed_ms_reg : elapsed_ms_reg + 16'd1;

    always_comb
    begin
        attempt_active_next      = attempt_active_reg;
        pending_peer_ip_next     = pending_peer_ip_reg;
        pending_remote_port_next = pending_remote_port_reg;
        pending_local_port_next  = pending_local_port_reg;
        initial_seq_next         = initial_seq_reg;
        elapsed_ms_next          = elapsed_ms_reg;
        port_counter_next        = port_counter_reg;
        result                   = '0;
        result.status            = tch_pkg::STAT_NONE;

        case (item.req_type)
            tch_pkg::REQ_CONNECT:
            begin
                if (item.remote_port == 16'd0)
                begin
                    result.status = tch_pkg::STAT_REJECTED;
                end
                else
                begin
                    port_counter_next        = port_pick;
                    attempt_active_next      = 1'b1;
                    pending_peer_ip_next     = item.peer_ip;
                    pending_remote_port_next = item.remote_port;
                    pending_local_port_next  = port_pick;
                    initial_seq_next         = isn;
                    elapsed_ms_next          = 16'd0;
                    result.send_valid        = 1'b1;
                    result.send_dst_ip       = item.peer_ip;
                    result.send_src_port     = port_pick;
                    result.send_dst_port     = item.remote_port;
                    result.send_seq          = isn;
                    result.send_flags        = tch_pkg::FLAG_SYN;
                end
            end
            tch_pkg::REQ_SEGMENT:
            begin
                if (hdr_ok && seg_match)
                begin
                    result.send_valid        = 1'b1;
                    result.send_dst_ip       = pending_peer_ip_reg;
                    result.send_src_port     = pending_local_port_reg;
                    result.send_dst_port     = pending_remote_port_reg;
                    result.send_seq          = isn_plus1;
                    result.send_ack          = item.rx_seq + 32'd1;
                    result.send_flags        = tch_pkg::FLAG_ACK;
                    result.status            = tch_pkg::STAT_CONNECTED;
                    attempt_active_next      = 1'b0;
                    pending_peer_ip_next     = 32'd0;
                    pending_remote_port_next = 16'd0;
                    pending_local_port_next  = 16'd0;
                    initial_seq_next         = 32'd0;
                    elapsed_ms_next          = 16'd0;
                end
            end
            tch_pkg::REQ_TICK:
            begin
                if (attempt_active_reg)
                begin
                    elapsed_ms_next = elapsed_inc;
                    if (elapsed_inc >= timeout_reg)
                    begin
                        result.status            = tch_pkg::STAT_TIMEOUT;
                        attempt_active_next      = 1'b0;
                        pending_peer_ip_next     = 32'd0;
                        pending_remote_port_next = 16'd0;
                        pending_local_port_next  = 16'd0;
                        initial_seq_next         = 32'd0;
                        elapsed_ms_next          = 16'd0;
                    end
                end
            end
            default:
            begin
                result.status = tch_pkg::STAT_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg             <= tch_pkg::TIMEOUT_RESET;
            attempt_active_reg      <= 1'b0;
            pending_peer_ip_reg     <= 32'd0;
            pending_remote_port_reg <= 16'd0;
            pending_local_port_reg  <= 16'd0;
            initial_seq_reg         <= 32'd0;
            elapsed_ms_reg          <= 16'd0;
            port_counter_reg        <= tch_pkg::PORT_START;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
            if (process)
            begin
                attempt_active_reg      <= attempt_active_next;
                pending_peer_ip_reg     <= pending_peer_ip_next;
                pending_remote_port_reg <= pending_remote_port_next;
                pending_local_port_reg  <= pending_local_port_next;
                initial_seq_reg         <= initial_seq_next;
                elapsed_ms_reg          <= elapsed_ms_next;
                port_counter_reg        <= port_counter_next;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_connect_clears : assert property (@(posedge clk) disable iff (!rst_n)
        (process && result.status == tch_pkg::STAT_CONNECTED) |=> !attempt_active_reg)
        else $error("attempt still active after connection");
    a_port_range : assert property (@(posedge clk) disable iff (!rst_n)
        attempt_active_reg |-> (pending_local_port_reg >= tch_pkg::PORT_LOW
                                && pending_local_port_reg <= tch_pkg::PORT_HIGH))
        else $error("pending local port out of ephemeral range");
    a_isn_odd : assert property (@(posedge clk) disable iff (!rst_n)
        attempt_active_reg |-> initial_seq_reg[0])
        else $error("pending ISN is even");
    a_idle_state_zero : assert property (@(posedge clk) disable iff (!rst_n)
        !attempt_active_reg |-> (initial_seq_reg == 32'd0 && elapsed_ms_reg == 16'd0))
        else $error("attempt fields not cleared while idle");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/tch_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module tch_out_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load_valid,
    input  wire tch_pkg::result_t load_result,
    output logic                  load_ok,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output tch_pkg::result_t      out_result
);

    logic             valid_reg;
    tch_pkg::result_t result_reg;

    // load when empty or when the held word drains this cycle
    assign load_ok = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load_ok)
            begin
                valid_reg <= load_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ok && load_valid)
        begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

>>> hw/rtl/tcp_client_handshake_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Client side of a TCP three-way handshake, one attempt at a time. Each input word
// (connect request, received segment header or millisecond tick) yields exactly one
// result word: a SYN on connect, the final ACK with status connected on a matching
// SYN+ACK, status timed out once the attempt ages to timeout_ms ticks, status
// rejected for a zero peer port, and otherwise an all-zero word with status nothing.
// One word is taken per clock cycle unless a full result register is held by a low
// out_ready; a word passes an input register, compare logic plus the ISN multiply,
// and the result register, from which its result is offered. Both registers hold
// while a full result register sees out_ready low; in_ready stays high as long as either has room.
// timeout_ms resets to 5000; the user must write it through cfg_wr_en/cfg_wr_data
// only while no word is in flight, as the block itself does not enforce this.

module tcp_client_handshake_core (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  req_type,
    input  wire logic [31:0] peer_ip,
    input  wire logic [15:0] remote_port,
    input  wire logic [31:0] now_ms,
    input  wire logic [31:0] rx_src_ip,
    input  wire logic [15:0] rx_src_port,
    input  wire logic [15:0] rx_dst_port,
    input  wire logic [7:0]  rx_flags,
    input  wire logic [31:0] rx_seq,
    input  wire logic [31:0] rx_ack,
    input  wire logic [3:0]  rx_data_offset,
    input  wire logic [15:0] rx_seg_len,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             send_valid,
    output logic [31:0]      send_dst_ip,
    output logic [15:0]      send_src_port,
    output logic [15:0]      send_dst_port,
    output logic [31:0]      send_seq,
    output logic [31:0]      send_ack,
    output logic [7:0]       send_flags,
    output logic [1:0]       status
);

    tch_pkg::item_t      in_item;
    tch_pkg::item_t      stage_item;
    tch_pkg::stage_ctl_t ctl;
    tch_pkg::result_t    comb_result;
    tch_pkg::result_t    out_result;
    logic                stage_valid;
    logic                load_ok;

    // gather the input fields into one word
    assign in_item.req_type       = req_type;
    assign in_item.peer_ip        = peer_ip;
    assign in_item.remote_port    = remote_port;
    assign in_item.now_ms         = now_ms;
    assign in_item.rx_src_ip      = rx_src_ip;
    assign in_item.rx_src_port    = rx_src_port;
    assign in_item.rx_dst_port    = rx_dst_port;
    assign in_item.rx_flags       = rx_flags;
    assign in_item.rx_seq         = rx_seq;
    assign in_item.rx_ack         = rx_ack;
    assign in_item.rx_data_offset = rx_data_offset;
    assign in_item.rx_seg_len     = rx_seg_len;

    tch_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .advance     (load_ok),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    // advance the held word whenever the result register can take its result
    assign ctl.valid   = stage_valid;
    assign ctl.advance = load_ok;

    tch_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ctl         (ctl),
        .item        (stage_item),
        .result      (comb_result)
    );

    tch_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (stage_valid),
        .load_result (comb_result),
        .load_ok     (load_ok),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_result  (out_result)
    );

    // split the result word back onto the output ports
    assign send_valid    = out_result.send_valid;
    assign send_dst_ip   = out_result.send_dst_ip;
    assign send_src_port = out_result.send_src_port;
    assign send_dst_port = out_result.send_dst_port;
    assign send_seq      = out_result.send_seq;
    assign send_ack      = out_result.send_ack;
    assign send_flags    = out_result.send_flags;
    assign status        = out_result.status;

endmodule

`default_nettype wire

>>> dv/tcp_client_handshake_core_tb.sv
`timescale 1ns / 1ps

module tcp_client_handshake_core_tb;

    // Protocol constants, kept local so that a wrong package value cannot hide itself
    localparam logic [7:0]  SYN_BIT         = 8'h02;
    localparam logic [7:0]  ACK_BIT         = 8'h10;
    localparam logic [31:0] ISN_FACTOR      = 32'd2654435761;
    localparam logic [15:0] EPH_FIRST       = 16'd40000;
    localparam logic [15:0] EPH_LOW         = 16'd32768;
    localparam logic [15:0] EPH_HIGH        = 16'd60999;
    localparam logic [15:0] TIMEOUT_DEFAULT = 16'd5000;
    localparam logic [15:0] TIMEOUT_CEILING = 16'hFFFF;
    localparam logic [1:0]  REQ_UNUSED      = 2'd3;

    localparam int STALL_LIMIT     = 5000;  // cycles with no word moving on either side
    localparam int SETTLE_CYCLES   = 8;     // well past the input and result register pipeline
    localparam int WORDS_PER_PHASE = 445;
    localparam int CEILING_TICKS   = 40;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [15:0]      cfg_wr_data = '0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    tch_pkg::item_t   drv = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic             send_valid;
    logic [31:0]      send_dst_ip;
    logic [15:0]      send_src_port;
    logic [15:0]      send_dst_port;
    logic [31:0]      send_seq;
    logic [31:0]      send_ack;
    logic [7:0]       send_flags;
    logic [1:0]       status;

    // Idle and stall rates in percent, changed between phases
    int src_idle_pct = 0;
    int sink_stall_pct = 0;

    int mismatch_count = 0;
    int quiet_cycles = 0;

    // Shadow of the connection state and the timeout register
    logic        conn_open;
    logic [31:0] conn_ip;
    logic [15:0] conn_remote_port;
    logic [15:0] conn_local_port;
    logic [31:0] conn_isn;
    logic [15:0] conn_age;
    logic [15:0] eph_port;
    logic [15:0] timeout_cfg;

    // Result words predicted for accepted requests, oldest first
    tch_pkg::result_t expected_replies[$];

    always #5 clk = ~clk;

    tcp_client_handshake_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (drv.req_type),
        .peer_ip        (drv.peer_ip),
        .remote_port    (drv.remote_port),
        .now_ms         (drv.now_ms),
        .rx_src_ip      (drv.rx_src_ip),
        .rx_src_port    (drv.rx_src_port),
        .rx_dst_port    (drv.rx_dst_port),
        .rx_flags       (drv.rx_flags),
        .rx_seq         (drv.rx_seq),
        .rx_ack         (drv.rx_ack),
        .rx_data_offset (drv.rx_data_offset),
        .rx_seg_len     (drv.rx_seg_len),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .send_valid     (send_valid),
        .send_dst_ip    (send_dst_ip),
        .send_src_port  (send_src_port),
        .send_dst_port  (send_dst_port),
        .send_seq       (send_seq),
        .send_ack       (send_ack),
        .send_flags     (send_flags),
        .status         (status)
    );

    // ------------------------------------------------------------------
    // Connection predictor
    // ------------------------------------------------------------------

    function automatic void drop_attempt();
        conn_open = 1'b0;
        conn_ip = '0;
        conn_remote_port = '0;
        conn_local_port = '0;
        conn_isn = '0;
        conn_age = '0;
    endfunction

    // Advance the shadow state by one request and return the reply word it causes
    function automatic tch_pkg::result_t client_reply(tch_pkg::item_t w);
        tch_pkg::result_t r;
        logic [15:0]      nxt;
        logic [5:0]       hdr_bytes;
        logic             hdr_ok;

        r = '0;
        r.status = tch_pkg::STAT_NONE;
        case (w.req_type)
            tch_pkg::REQ_CONNECT:
            begin
                if (w.remote_port == 16'd0)
                begin
                    // Reject; leave the port counter and any open attempt alone
                    r.status = tch_pkg::STAT_REJECTED;
                end
                else
                begin
                    nxt = eph_port + 16'd1;
                    if (nxt < EPH_LOW || nxt > EPH_HIGH)
                        nxt = EPH_LOW;
                    eph_port = nxt;
                    conn_open = 1'b1;
                    conn_ip = w.peer_ip;
                    conn_remote_port = w.remote_port;
                    conn_local_port = nxt;
                    conn_isn = (w.now_ms * ISN_FACTOR) | 32'd1;
                    conn_age = '0;
                    r.send_valid = 1'b1;
                    r.send_dst_ip = w.peer_ip;
                    r.send_src_port = nxt;
                    r.send_dst_port = w.remote_port;
                    r.send_seq = conn_isn;
                    r.send_ack = '0;
                    r.send_flags = SYN_BIT;
                end
            end
            tch_pkg::REQ_SEGMENT:
            begin
                hdr_bytes = {w.rx_data_offset, 2'b00};
                hdr_ok = (w.rx_seg_len >= 16'd20) && (hdr_bytes >= 6'd20)
                         && (hdr_bytes <= w.rx_seg_len);
                if (hdr_ok && conn_open
                    && w.rx_dst_port == conn_local_port
                    && w.rx_src_port == conn_remote_port
                    && w.rx_src_ip == conn_ip
                    && (w.rx_flags & (SYN_BIT | ACK_BIT)) == (SYN_BIT | ACK_BIT)
                    && w.rx_ack == conn_isn + 32'd1)
                begin
                    r.send_valid = 1'b1;
                    r.send_dst_ip = conn_ip;
                    r.send_src_port = conn_local_port;
                    r.send_dst_port = conn_remote_port;
                    r.send_seq = conn_isn + 32'd1;
                    r.send_ack = w.rx_seq + 32'd1;
                    r.send_flags = ACK_BIT;
                    r.status = tch_pkg::STAT_CONNECTED;
                    drop_attempt();
                end
            end
            tch_pkg::REQ_TICK:
            begin
                if (conn_open)
                begin
                    // Age saturates at the top of its range
                    if (conn_age != 16'hFFFF)
                        conn_age = conn_age + 16'd1;
                    if (conn_age >= timeout_cfg)
                    begin
                        r.status = tch_pkg::STAT_TIMEOUT;
                        drop_attempt();
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------

    // Fill every field with random bits, request code included
    function automatic tch_pkg::item_t noise_word();
        tch_pkg::item_t w;

        w.req_type = 2'($urandom);
        w.peer_ip = $urandom;
        w.remote_port = 16'($urandom);
        w.now_ms = $urandom;
        w.rx_src_ip = $urandom;
        w.rx_src_port = 16'($urandom);
        w.rx_dst_port = 16'($urandom);
        w.rx_flags = 8'($urandom);
        w.rx_seq = $urandom;
        w.rx_ack = $urandom;
        w.rx_data_offset = 4'($urandom);
        w.rx_seg_len = 16'($urandom);
        return w;
    endfunction

    function automatic tch_pkg::item_t connect_word();
        tch_pkg::item_t w;

        w = noise_word();
        w.req_type = tch_pkg::REQ_CONNECT;
        if (w.remote_port == 16'd0)
            w.remote_port = 16'd1;
        return w;
    endfunction

    // SYN+ACK that answers the open attempt, with a valid header and random extras
    function automatic tch_pkg::item_t synack_word();
        tch_pkg::item_t w;

        w = noise_word();
        w.req_type = tch_pkg::REQ_SEGMENT;
        w.rx_src_ip = conn_ip;
        w.rx_src_port = conn_remote_port;
        w.rx_dst_port = conn_local_port;
        w.rx_flags = w.rx_flags | SYN_BIT | ACK_BIT;
        w.rx_ack = conn_isn + 32'd1;
        w.rx_data_offset = 4'($urandom_range(15, 5));
        if ($urandom_range(1) == 0)
            w.rx_seg_len = 16'(w.rx_data_offset * 4 + $urandom_range(3));
        else
            w.rx_seg_len = 16'($urandom_range(65535, w.rx_data_offset * 4));
        return w;
    endfunction

    // Mostly well-formed handshakes with random content, plus near misses and noise
    function automatic tch_pkg::item_t traffic_word();
        tch_pkg::item_t w;
        int             roll;

        roll = $urandom_range(99);
        w = noise_word();
        if (roll < 20)
        begin
            w = connect_word();
            if (roll < 3)
                w.remote_port = 16'd0;
        end
        else if (roll < 52)
            w = synack_word();
        else if (roll < 66)
        begin
            // Spoil exactly one thing the match depends on
            w = synack_word();
            case ($urandom_range(7))
                0: w.rx_dst_port ^= 16'd1 << $urandom_range(15);
                1: w.rx_src_port ^= 16'd1 << $urandom_range(15);
                2: w.rx_src_ip ^= 32'd1 << $urandom_range(31);
                3: w.rx_flags &= ~SYN_BIT;
                4: w.rx_flags &= ~ACK_BIT;
                5: w.rx_ack ^= 32'd1 << $urandom_range(31);
                6: w.rx_data_offset = 4'($urandom_range(4));
                default: w.rx_seg_len = 16'(w.rx_data_offset * 4 - 1 - $urandom_range(3));
            endcase
        end
        else if (roll < 72)
            w.req_type = tch_pkg::REQ_SEGMENT;
        else if (roll < 97)
            w.req_type = tch_pkg::REQ_TICK;
        else
            w.req_type = REQ_UNUSED;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Hold the word until accepted, then predict its reply. Called and left at a
    // falling edge; a word that follows at once keeps valid high across the edge.
    task automatic send_word(input tch_pkg::item_t w);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        drv = w;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_replies.push_back(client_reply(w));
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Write the timeout only once every reply is back and the pipe has emptied
    task automatic set_timeout(input logic [15:0] value);
        in_valid = 1'b0;
        while (expected_replies.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        cfg_wr_data = 16'($urandom);
        timeout_cfg = value;
    endtask

    // Receiver side: decide each cycle whether to take a reply word
    always @(negedge clk)
        out_ready = ($urandom_range(99) >= sink_stall_pct);

    // ------------------------------------------------------------------
    // Reply checking
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        tch_pkg::result_t want;

        if (rst_n && out_valid && out_ready)
        begin
            if (expected_replies.size() == 0)
            begin
                $display("%t: reply word with none expected, expected nothing, actual status %h",
                         $time, status);
                mismatch_count++;
            end
            else
            begin
                want = expected_replies.pop_front();
                check_field("send_valid", want.send_valid, send_valid);
                check_field("send_dst_ip", want.send_dst_ip, send_dst_ip);
                check_field("send_src_port", want.send_src_port, send_src_port);
                check_field("send_dst_port", want.send_dst_port, send_dst_port);
                check_field("send_seq", want.send_seq, send_seq);
                check_field("send_ack", want.send_ack, send_ack);
                check_field("send_flags", want.send_flags, send_flags);
                check_field("status", want.status, status);
            end
        end
    end

    // Watchdog: end the run when no word moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Requests that arrive with no attempt open, and a zero peer port
    task automatic test_unprompted_requests();
        tch_pkg::item_t w;

        w = noise_word();
        w.req_type = tch_pkg::REQ_TICK;
        send_word(w);
        send_word(synack_word());
        w = noise_word();
        w.req_type = REQ_UNUSED;
        send_word(w);
        w = connect_word();
        w.remote_port = 16'd0;
        send_word(w);
    endtask

    // Connect at field extremes, feed header and match failures, then complete
    task automatic test_connect_and_accept();
        tch_pkg::item_t w;

        w = connect_word();
        w.peer_ip = 32'hFFFF_FFFF;
        w.remote_port = 16'hFFFF;
        w.now_ms = 32'd0;
        send_word(w);

        // Segment shorter than a header
        w = synack_word();
        w.rx_data_offset = 4'd5;
        w.rx_seg_len = 16'd19;
        send_word(w);
        // Header field below five words
        w = synack_word();
        w.rx_data_offset = 4'd4;
        w.rx_seg_len = 16'hFFFF;
        send_word(w);
        // Header longer than the segment
        w = synack_word();
        w.rx_data_offset = 4'd15;
        w.rx_seg_len = 16'd59;
        send_word(w);
        // SYN alone, ACK alone, wrong acknowledgement, wrong local port
        w = synack_word();
        w.rx_flags = SYN_BIT;
        send_word(w);
        w = synack_word();
        w.rx_flags = ACK_BIT;
        send_word(w);
        w = synack_word();
        w.rx_ack = conn_isn;
        send_word(w);
        w = synack_word();
        w.rx_dst_port = conn_local_port + 16'd1;
        send_word(w);

        // Largest header, all flags, peer sequence that wraps to zero
        w = synack_word();
        w.rx_flags = 8'hFF;
        w.rx_data_offset = 4'd15;
        w.rx_seg_len = 16'hFFFF;
        w.rx_seq = 32'hFFFF_FFFF;
        send_word(w);

        w = connect_word();
        w.peer_ip = 32'd0;
        w.remote_port = 16'd1;
        w.now_ms = 32'hFFFF_FFFF;
        send_word(w);
        // Smallest valid header, exact flags
        w = synack_word();
        w.rx_flags = SYN_BIT | ACK_BIT;
        w.rx_data_offset = 4'd5;
        w.rx_seg_len = 16'd20;
        w.rx_seq = 32'd0;
        send_word(w);
    endtask

    // A new connect replaces the pending one; a rejected one leaves it in place
    task automatic test_attempt_replaced();
        tch_pkg::item_t stale;
        tch_pkg::item_t w;

        send_word(connect_word());
        stale = synack_word();
        send_word(connect_word());
        send_word(stale);
        send_word(synack_word());

        send_word(connect_word());
        w = connect_word();
        w.remote_port = 16'd0;
        send_word(w);
        send_word(synack_word());
    endtask

    // Timeout of one tick: the first tick fails the attempt, a late answer is dropped
    task automatic test_timeout_floor();
        tch_pkg::item_t late;
        tch_pkg::item_t w;

        set_timeout(16'd1);
        send_word(connect_word());
        late = synack_word();
        w = noise_word();
        w.req_type = tch_pkg::REQ_TICK;
        send_word(w);
        send_word(w);
        send_word(late);
    endtask

    // Largest timeout: ticks age the attempt without failing it, the answer still connects
    task automatic test_timeout_ceiling();
        tch_pkg::item_t w;

        set_timeout(TIMEOUT_CEILING);
        send_word(connect_word());
        w = noise_word();
        w.req_type = tch_pkg::REQ_TICK;
        repeat (CEILING_TICKS)
            send_word(w);
        send_word(synack_word());
    endtask

    // Random traffic under one timeout and one idling pattern
    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input logic [15:0] timeout_value);
        set_timeout(timeout_value);
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        repeat (WORDS_PER_PHASE)
            send_word(traffic_word());
    endtask

    initial
    begin
        timeout_cfg = TIMEOUT_DEFAULT;
        eph_port = EPH_FIRST;
        drop_attempt();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed checks run with no idling on either side
        test_unprompted_requests();
        test_connect_and_accept();
        test_attempt_replaced();
        test_timeout_floor();
        test_timeout_ceiling();

        test_random_traffic(0, 0, 16'($urandom_range(30, 3)));
        test_random_traffic(83, 0, 16'($urandom_range(8, 2)));
        test_random_traffic(0, 83, 16'd1);
        test_random_traffic(13, 13, TIMEOUT_DEFAULT);

        // Drain the replies still in flight, then let the pipe settle
        in_valid = 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
